// ----- rtl/stable_min_priority_queue_assert.svh -----
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue check failed");

// next-cycle implication, checked out of reset
`define SMPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue check failed");

`endif

// ----- rtl/smpq_pkg.sv -----
package smpq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int PRIO_W       = 16;
   localparam int OCC_W        = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic                      operation;
      logic signed [VALUE_W-1:0] item_value;
      logic signed [PRIO_W-1:0]  item_priority;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] removed_value;
      logic signed [PRIO_W-1:0]  removed_priority;
      logic        [OCC_W-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] data;
      logic signed [PRIO_W-1:0]  prio;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } cmd_type;

endpackage

// ----- rtl/smpq_cell.sv -----
module smpq_cell (
   input  logic                clock,
   input  smpq_pkg::cmd_type   cmd,
   input  logic                occupied,
   input  logic                left_stays,
   input  smpq_pkg::entry_type left_entry,
   input  smpq_pkg::entry_type right_entry,
   output smpq_pkg::entry_type entry,
   output logic                stays
);

   smpq_pkg::entry_type entry_ff;
   smpq_pkg::entry_type entry_in;

   assign stays = occupied && (entry_ff.prio <= cmd.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.insert) begin
         if (stays) begin
            entry_in = entry_ff;
         end else if (left_stays) begin
            entry_in = cmd.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/stable_min_priority_queue.sv -----
// An accepted req item's rsp item is registered, valid in the next cycle.
// Throughput: one item per cycle unless rsp_ready stalls; every cell of the
// sorted chain compares and shifts in parallel on each insert or remove.
// Reset: synchronous, active high; empties the queue and drops any pending rsp.
// Entry contents are not reset; only cells below the fill count are read.
module stable_min_priority_queue #(
   parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smpq_pkg::rsp_type rsp_data
);

   `include "stable_min_priority_queue_assert.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int OW = smpq_pkg::OCC_W;

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   smpq_pkg::rsp_type   rsp_ff;
   smpq_pkg::rsp_type   rsp_in;

   logic                req_fire;
   logic                full;
   logic                empty;
   logic                do_insert;
   logic                do_remove;
   smpq_pkg::cmd_type   cmd;

   smpq_pkg::entry_type cell_entry [CAPACITY];
   logic [CAPACITY-1:0] cell_stays;
   logic [CAPACITY-1:0] cell_occupied;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign do_insert = req_fire && (req_data.operation == smpq_pkg::OP_INSERT) && !full;
   assign do_remove = req_fire && (req_data.operation == smpq_pkg::OP_REMOVE) && !empty;

   assign cmd.insert         = do_insert;
   assign cmd.remove         = do_remove;
   assign cmd.new_entry.data = req_data.item_value;
   assign cmd.new_entry.prio = req_data.item_priority;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      smpq_pkg::entry_type left_entry;
      smpq_pkg::entry_type right_entry;
      logic                left_stays;

      assign cell_occupied[i] = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = cmd.new_entry;
         assign left_stays = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_stays = cell_stays[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      smpq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (cell_occupied[i]),
         .left_stays  (left_stays),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .stays       (cell_stays[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in                  = rsp_ff;
      rsp_in.removed_value    = '0;
      rsp_in.removed_priority = '0;
      rsp_in.occupancy        = OW'(count_in);
      if (req_data.operation == smpq_pkg::OP_INSERT) begin
         rsp_in.status = full ? smpq_pkg::ST_OVERFLOW : smpq_pkg::ST_INSERTED;
      end else if (empty) begin
         rsp_in.status = smpq_pkg::ST_UNDERFLOW;
      end else begin
         rsp_in.status           = smpq_pkg::ST_REMOVED;
         rsp_in.removed_value    = cell_entry[0].data;
         rsp_in.removed_priority = cell_entry[0].prio;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SMPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `SMPQ_ASSERT_NEXT(a_insert_grows, clock, reset, do_insert,
      count_ff == $past(count_ff) + CW'(1))
   `SMPQ_ASSERT_NEXT(a_remove_status, clock, reset, do_remove,
      rsp_valid_ff && (rsp_ff.status == smpq_pkg::ST_REMOVED))
   `SMPQ_ASSERT_NOW(a_occ_matches, clock, reset, rsp_valid_ff,
      rsp_ff.occupancy == OW'(count_ff))

endmodule
